// ===== hw/rtl/ncc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncc_pkg: shared types and constants of the nearest color classifier
// Holds the item structs passed along the cell chain, the preset reset values,
// the preset tone-down function and the confidence constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

  // number of preset cells in the chain (1..8)
  localparam int NumPresets  = 5;
  // presets that own a configuration register
  localparam int CfgPresets  = 5;

  localparam int CompW       = 8;
  localparam int ClassW      = 3;
  localparam int DistW       = 9;
  localparam int ConfW       = 7;
  localparam int PresetW     = 24;
  localparam int CfgIdxW     = 3;
  localparam int SumSqW      = 18;
  localparam int RemW        = 10;
  localparam int IsqrtSteps  = SumSqW / 2;
  localparam int StepCntW    = $clog2(IsqrtSteps + 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBlackClass = CfgIdxW'(CfgPresets);

  // tone-down of preset components
  localparam logic [CompW-1:0] ToneLow  = CompW'(50);
  localparam logic [CompW-1:0] ToneHigh = CompW'(205);
  localparam logic [CompW-1:0] CompMax  = CompW'(255);

  // confidence = floor((467 - dist) * 100 / 442), saturated at 100
  localparam int NumW       = 16;
  localparam int ProdW      = 32;
  localparam int RecipShift = 24;
  localparam int ConfBase   = 467;
  localparam int ConfScale  = 100;
  localparam int ConfDiv    = 442;
  localparam int ConfRecip  = ((1 << RecipShift) + ConfDiv - 1) / ConfDiv;
  localparam logic [ConfW-1:0] ConfMax = ConfW'(100);

  typedef struct packed {
    logic               vld;
    logic [CompW-1:0]   red;
    logic [CompW-1:0]   green;
    logic [CompW-1:0]   blue;
  } samp_t;

  typedef struct packed {
    logic               vld;
    logic [DistW-1:0]   distance;
    logic [ClassW-1:0]  idx;
  } best_t;

  typedef struct packed {
    logic               vld;
    logic [CfgIdxW-1:0] idx;
    logic [PresetW-1:0] data;
  } cfg_wr_t;

  function automatic logic [PresetW-1:0] preset_reset(input logic [ClassW-1:0] idx);
    logic [PresetW-1:0] val;
    case (idx)
      3'd0:    val = 24'h000000;
      3'd1:    val = 24'hFFFFFF;
      3'd2:    val = 24'hFF0000;
      3'd3:    val = 24'h00FF00;
      3'd4:    val = 24'h0000FF;
      default: val = 24'h000000;
    endcase
    return val;
  endfunction

  function automatic logic [CompW-1:0] tone_down(input logic [CompW-1:0] v);
    logic [CompW-1:0] res;
    if (v == '0) begin
      res = ToneLow;
    end else if (v == CompMax) begin
      res = ToneHigh;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ncc_if.sv =====
// ----------------------------------------------------------------------------
// ncc_if: channel interfaces of the nearest color classifier
// Sample input, result output and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ncc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] color_class;
  logic [8:0] best_distance;
  logic       black_shortcut;
  logic [6:0] confidence_pct;

  modport source (output valid, output color_class, output best_distance,
                  output black_shortcut, output confidence_pct, input ready);
  modport sink   (input valid, input color_class, input best_distance,
                  input black_shortcut, input confidence_pct, output ready);
endinterface

interface ncc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ncc_cell.sv =====
// ----------------------------------------------------------------------------
// ncc_cell: one preset cell of the classifier chain
// Holds one preset, forms the squared distance to the passing sample, takes
// its integer square root one bit per cycle and merges into the running best.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ncc_pkg::ClassW-1:0]          cell_idx_i,
  input  ncc_pkg::cfg_wr_t                    cfg_i,
  input  ncc_pkg::samp_t                      samp_i,
  input  ncc_pkg::best_t                      best_i,
  output ncc_pkg::samp_t                      samp_o,
  output ncc_pkg::best_t                      best_o
);
  import ncc_pkg::*;

  logic [PresetW-1:0]  preset_q;
  samp_t               samp_q;
  logic [SumSqW-1:0]   x_q, x_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [DistW-1:0]    root_q, root_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                fin_q;
  best_t               best_q, best_d;

  logic                wr_en;
  logic [CompW-1:0]    tr, tg, tb;
  logic [CompW-1:0]    dr, dg, db;
  logic [SumSqW-1:0]   sumsq;
  logic [RemW+1:0]     rem_sh, trial, rem_sub;
  logic                ge;

  assign wr_en = cfg_i.vld && (cfg_i.idx == cell_idx_i) &&
                 ({1'b0, cell_idx_i} < (ClassW + 1)'(CfgPresets));

  // squared distance to the toned-down preset
  always_comb begin
    tr = tone_down(preset_q[23:16]);
    tg = tone_down(preset_q[15:8]);
    tb = tone_down(preset_q[7:0]);
    dr = (samp_i.red   >= tr) ? samp_i.red   - tr : tr - samp_i.red;
    dg = (samp_i.green >= tg) ? samp_i.green - tg : tg - samp_i.green;
    db = (samp_i.blue  >= tb) ? samp_i.blue  - tb : tb - samp_i.blue;
    sumsq = (SumSqW'(dr) * SumSqW'(dr)) + (SumSqW'(dg) * SumSqW'(dg)) +
            (SumSqW'(db) * SumSqW'(db));
  end

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh  = {rem_q, x_q[SumSqW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (rem_sh >= trial);
    rem_sub = ge ? rem_sh - trial : rem_sh;

    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (samp_i.vld) begin
      x_d    = sumsq;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = StepCntW'(IsqrtSteps);
    end else if (cnt_q != '0) begin
      x_d    = {x_q[SumSqW-3:0], 2'b00};
      rem_d  = rem_sub[RemW-1:0];
      root_d = {root_q[DistW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end
  end

  // merge: lower index wins ties, so only a strictly smaller root replaces
  always_comb begin
    best_d.vld = fin_q;
    if (!best_i.vld || (root_q < best_i.distance)) begin
      best_d.distance = root_q;
      best_d.idx      = cell_idx_i;
    end else begin
      best_d.distance = best_i.distance;
      best_d.idx      = best_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= preset_reset(cell_idx_i);
      samp_q   <= '0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      best_q   <= '0;
    end else begin
      if (wr_en) begin
        preset_q <= cfg_i.data;
      end
      samp_q <= samp_i;
      cnt_q  <= cnt_d;
      fin_q  <= (cnt_q == StepCntW'(1)) && !samp_i.vld;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign samp_o = samp_q;
  assign best_o = best_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_color_classifier_core.sv =====
// ----------------------------------------------------------------------------
// nearest_color_classifier_core: nearest preset color classifier
// Classifies one RGB sample against the configured presets through a chain
// of preset cells and reports class, distance, black shortcut and confidence.
// ----------------------------------------------------------------------------
// a non-black item walks the cell chain, then S_MUL and S_CONF form the
//   confidence and S_DONE loads the output; an all-zero item goes to S_DONE
// one item in flight: a new item is taken only once the output register has
//   loaded the last one, paced by the per-cell square root, one root bit per
//   cycle, the chain depth the sample walks through and output stalls
// reset: presets to their defaults, black class and kept confidence to zero
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_color_classifier_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  ncc_in_if.sink   in_i,
  ncc_cfg_if.sink  cfg_i,
  ncc_out_if.source out_o
);
  import ncc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_MUL,
    S_CONF,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [DistW-1:0]  distance;
    logic              blk;
    logic [ConfW-1:0]  conf;
  } res_t;

  state_e             state_q;
  res_t               res_q;
  res_t               out_q;
  logic               out_vld_q;
  logic [ClassW-1:0]  black_class_q;
  logic [ConfW-1:0]   kept_q;
  logic [NumW-1:0]    num_q;
  logic [ProdW-1:0]   prod_q;

  samp_t              samp_chain [NumPresets+1];
  best_t              best_chain [NumPresets+1];
  cfg_wr_t            cfg_wr;

  logic               in_fire;
  logic               is_black;
  logic               out_free;
  best_t              last;
  logic [DistW-1:0]   conf_diff;
  logic [NumW-1:0]    num_d;
  logic [ProdW-1:0]   prod_d;
  logic [ConfW:0]     conf_raw;
  logic [ConfW-1:0]   conf_sat;

  // handshakes: one item in flight, output register decoupled from input
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_vld_q || out_o.ready;

  assign is_black = (in_i.red == '0) && (in_i.green == '0) && (in_i.blue == '0);

  // config write broadcast to the cells
  always_comb begin
    cfg_wr.vld  = cfg_i.valid && cfg_i.ready;
    cfg_wr.idx  = cfg_i.index;
    cfg_wr.data = cfg_i.data;
  end

  // sample enters the first cell straight from the input channel
  assign samp_chain[0] = {in_fire && !is_black, in_i.red, in_i.green, in_i.blue};
  assign best_chain[0] = '0;

  // cell k sees the sample through the sample registers of the cells before it,
  // and its best in the cycle after cell k-1 has merged, so the running minimum walks with the sample
  for (genvar k = 0; k < NumPresets; k++) begin : g_cell
    ncc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (ClassW'(k)),
      .cfg_i      (cfg_wr),
      .samp_i     (samp_chain[k]),
      .best_i     (best_chain[k]),
      .samp_o     (samp_chain[k+1]),
      .best_o     (best_chain[k+1])
    );
  end

  assign last = best_chain[NumPresets];

  // confidence: (467 - dist) * 100, then divide by 442 via reciprocal multiply
  always_comb begin
    conf_diff = DistW'(ConfBase) - last.distance;
    num_d     = NumW'(conf_diff) * NumW'(ConfScale);
    prod_d    = ProdW'(num_q) * ProdW'(ConfRecip);
    conf_raw  = prod_q[RecipShift +: (ConfW + 1)];
    conf_sat  = (conf_raw > {1'b0, ConfMax}) ? ConfMax : conf_raw[ConfW-1:0];
  end

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_vld_q     <= 1'b0;
      black_class_q <= '0;
      kept_q        <= '0;
    end else begin
      if (cfg_wr.vld && (cfg_wr.idx == RegBlackClass)) begin
        black_class_q <= cfg_wr.data[ClassW-1:0];
      end
      // output register loads in the done state, drops once taken
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (is_black) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (last.vld) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_CONF;
        end
        S_CONF: begin
          kept_q  <= conf_sat;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_q.cls      <= black_class_q;
          res_q.distance <= '0;
          res_q.blk      <= 1'b1;
          res_q.conf     <= kept_q;
        end
      end
      S_RUN: begin
        if (last.vld) begin
          res_q.cls      <= last.idx;
          res_q.distance <= last.distance;
          res_q.blk      <= 1'b0;
        end
      end
      S_CONF: begin
        res_q.conf <= conf_sat;
      end
      S_DONE: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.color_class    = out_q.cls;
  assign out_o.best_distance  = out_q.distance;
  assign out_o.black_shortcut = out_q.blk;
  assign out_o.confidence_pct = out_q.conf;

  // chain result only arrives while an item is being classified
  a_last_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.vld |-> (state_q == S_RUN))
    else $error("chain result outside of run state");

  // a non-black item enters the first cell
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_black) |=> (samp_chain[1].vld && state_q == S_RUN))
    else $error("sample not launched into chain");

  // black shortcut reports zero distance
  a_black_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.blk) |-> (out_q.distance == '0))
    else $error("black shortcut with nonzero distance");

  // kept confidence stays saturated
  a_kept_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (kept_q <= ConfMax))
    else $error("kept confidence above maximum");

endmodule

`default_nettype wire

// ===== bench/ncc_result_checker.sv =====
// ----------------------------------------------------------------------------
// ncc_result_checker: result checker of the nearest color classifier
// Watches the sample, configuration and result channels, keeps its own copy
// of presets, black class and kept confidence, predicts each result and
// compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ncc_in_if    in_i,
  ncc_cfg_if   cfg_i,
  ncc_out_if   res_i,
  output int   fail_count_o,
  output int   open_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import ncc_pkg::*;

  // chain length as the block builds it
  localparam int ChainLen   = (NumPresets < 1) ? 1 : ((NumPresets > 8) ? 8 : NumPresets);
  localparam int ConfOffset = 467;
  localparam int ConfPct    = 100;
  localparam int ConfSpan   = 442;

  typedef struct packed {
    logic [ClassW-1:0] color_class;
    logic [DistW-1:0]  best_distance;
    logic              black_shortcut;
    logic [ConfW-1:0]  confidence_pct;
  } color_result_t;

  logic [PresetW-1:0] preset_q [CfgPresets];
  logic [ClassW-1:0]  black_class_q;
  logic [ConfW-1:0]   kept_conf_q;
  color_result_t      expected_colors [$];
  int                 mismatch_count = 0;
  int                 open_results   = 0;

  assign fail_count_o = mismatch_count;
  assign open_count_o = open_results;

  // preset components are pulled away from the rails before comparison
  function automatic int toned(input logic [CompW-1:0] c);
    if (c == 8'd0) return 50;
    if (c == 8'd255) return 205;
    return int'(c);
  endfunction

  // floor of the square root, one bit at a time
  function automatic int floor_root(input int sum);
    int root;
    int cand;
    root = 0;
    for (int b = DistW - 1; b >= 0; b--) begin
      cand = root | (1 << b);
      if (cand * cand <= sum) root = cand;
    end
    return root;
  endfunction

  function automatic color_result_t nearest_color(input logic [CompW-1:0] r,
                                                  input logic [CompW-1:0] g,
                                                  input logic [CompW-1:0] b);
    color_result_t      res;
    logic [PresetW-1:0] p;
    int                 dr, dg, db, d, best_d, best_i, conf;
    if (r == '0 && g == '0 && b == '0) begin
      res.color_class    = black_class_q;
      res.best_distance  = '0;
      res.black_shortcut = 1'b1;
      res.confidence_pct = kept_conf_q;
      return res;
    end
    best_d = 0;
    best_i = 0;
    for (int i = 0; i < ChainLen; i++) begin
      p  = (i < CfgPresets) ? preset_q[i] : '0;
      dr = int'(r) - toned(p[23:16]);
      dg = int'(g) - toned(p[15:8]);
      db = int'(b) - toned(p[7:0]);
      d  = floor_root(dr * dr + dg * dg + db * db);
      // first of equal distances wins
      if (i == 0 || d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    conf = ((ConfOffset - best_d) * ConfPct) / ConfSpan;
    if (conf > ConfPct) conf = ConfPct;
    res.color_class    = ClassW'(best_i);
    res.best_distance  = DistW'(best_d);
    res.black_shortcut = 1'b0;
    res.confidence_pct = ConfW'(conf);
    return res;
  endfunction

  function automatic int field_differs(input string fname, input int want, input int got);
    if (want == got) return 0;
    $display("%0t ns: %s expected %0d actual %0d", $time, fname, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    color_result_t want;
    int            bad;
    if (!rst_ni) begin
      preset_q[0]   = 24'h000000;
      preset_q[1]   = 24'hFFFFFF;
      preset_q[2]   = 24'hFF0000;
      preset_q[3]   = 24'h00FF00;
      preset_q[4]   = 24'h0000FF;
      black_class_q = '0;
      kept_conf_q   = '0;
      expected_colors.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index < CfgPresets) begin
          preset_q[cfg_i.index] = cfg_i.data;
        end else if (cfg_i.index == RegBlackClass) begin
          black_class_q = cfg_i.data[ClassW-1:0];
        end
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t ns: result with nothing expected, class %0d distance %0d",
                   $time, res_i.color_class, res_i.best_distance);
          mismatch_count++;
        end else begin
          want = expected_colors.pop_front();
          bad  = field_differs("color_class", want.color_class, res_i.color_class)
               + field_differs("best_distance", want.best_distance, res_i.best_distance)
               + field_differs("black_shortcut", want.black_shortcut, res_i.black_shortcut)
               + field_differs("confidence_pct", want.confidence_pct, res_i.confidence_pct);
          if (bad != 0) mismatch_count++;
        end
      end
      if (in_i.valid && in_i.ready) begin
        want = nearest_color(in_i.red, in_i.green, in_i.blue);
        if (!want.black_shortcut) kept_conf_q = want.confidence_pct;
        expected_colors.push_back(want);
      end
    end
    open_results = expected_colors.size();
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top of the nearest color classifier bench
// Drives samples and register writes into the core with random gaps and
// result stalls, runs several preset settings, and reports the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ncc_pkg::*;

  // register slots past black class have no register behind them
  localparam logic [CfgIdxW-1:0] RegSpareLo = RegBlackClass + CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSpareHi = RegBlackClass + CfgIdxW'(2);

  localparam int NumPhases       = 6;
  localparam int SamplesPerPhase = 330;
  localparam int IdlePct         = 13;
  // phase run without any gaps or stalls
  localparam int QuietPhase      = 3;
  // a non-black item is the slowest to finish, leave some margin
  localparam int DrainCycles     = 40;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   fail_count;
  int   open_count;

  // presets as last written, used to aim samples close to them
  logic [PresetW-1:0] live_preset [CfgPresets];

  ncc_in_if  sample_ch ();
  ncc_cfg_if cfg_ch ();
  ncc_out_if result_ch ();

  nearest_color_classifier_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_ch),
    .cfg_i  (cfg_ch),
    .out_o  (result_ch)
  );

  ncc_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (sample_ch),
    .cfg_i        (cfg_ch),
    .res_i        (result_ch),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  always #10 clk_i = ~clk_i;

  // result side stalls at random except in the quiet phase
  always @(negedge clk_i) begin
    result_ch.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
  end

  // hand one sample over, with random gaps in front of it; valid stays up
  // afterwards so back-to-back items need no extra edge
  task automatic send_sample(input logic [CompW-1:0] r, input logic [CompW-1:0] g,
                             input logic [CompW-1:0] b);
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.red   <= r;
    sample_ch.green <= g;
    sample_ch.blue  <= b;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PresetW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    sample_ch.valid <= 1'b0;
    wait (open_count == 0);
    @(negedge clk_i);
  endtask

  // components biased toward the rails and the tone-down values
  function automatic logic [CompW-1:0] pick_comp();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'd254;
      4:       return 8'd50;
      5:       return 8'd205;
      default: return CompW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CompW-1:0] near_comp(input logic [CompW-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CompW'(v);
  endfunction

  function automatic logic [PresetW-1:0] rand_sample();
    logic [PresetW-1:0] p;
    int                 sel;
    sel = $urandom_range(0, 99);
    if (sel < 6) return '0;                       // all-zero black shortcut
    if (sel < 24) begin                           // close to a live preset
      p = live_preset[$urandom_range(0, CfgPresets - 1)];
      return {near_comp(p[23:16]), near_comp(p[15:8]), near_comp(p[7:0])};
    end
    if (sel < 38) return {pick_comp(), pick_comp(), pick_comp()};
    return PresetW'($urandom());
  endfunction

  // setting 0: all presets white and black class 7, setting 1: all presets
  // zero and black class 4 with junk in the upper bits, later ones random
  task automatic load_presets(input int setting);
    logic [PresetW-1:0] p;
    logic [PresetW-1:0] blk;
    for (int i = 0; i < CfgPresets; i++) begin
      case (setting)
        0:       p = '1;
        1:       p = '0;
        default: p = {pick_comp(), pick_comp(), pick_comp()};
      endcase
      write_reg(CfgIdxW'(i), p);
      live_preset[i] = p;
    end
    case (setting)
      0:       blk = '1;
      1:       blk = 24'hFFFFF4;
      default: blk = PresetW'($urandom());
    endcase
    write_reg(RegBlackClass, blk);
    // writes to slots without a register must leave everything alone
    if (setting == 0 || $urandom_range(0, 1) == 1) begin
      write_reg(RegSpareLo, PresetW'($urandom()));
      write_reg(RegSpareHi, PresetW'($urandom()));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PresetW-1:0] s;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    quiet           = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.red   = '0;
    sample_ch.green = '0;
    sample_ch.blue  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;
    live_preset[0]  = 24'h000000;
    live_preset[1]  = 24'hFFFFFF;
    live_preset[2]  = 24'hFF0000;
    live_preset[3]  = 24'h00FF00;
    live_preset[4]  = 24'h0000FF;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset presets
    send_sample(8'd0, 8'd0, 8'd0);        // black before any confidence was kept
    send_sample(8'd255, 8'd255, 8'd255);
    send_sample(8'd0, 8'd0, 8'd0);        // black keeps the previous confidence
    send_sample(8'd1, 8'd0, 8'd0);
    send_sample(8'd0, 8'd1, 8'd0);
    send_sample(8'd0, 8'd0, 8'd1);        // only blue nonzero is not black
    send_sample(8'd254, 8'd254, 8'd254);
    send_sample(8'd50, 8'd50, 8'd50);     // exactly on toned black preset
    send_sample(8'd205, 8'd205, 8'd205);
    send_sample(8'd205, 8'd50, 8'd50);
    send_sample(8'd50, 8'd205, 8'd50);
    send_sample(8'd50, 8'd50, 8'd205);
    send_sample(8'd255, 8'd0, 8'd0);
    send_sample(8'd0, 8'd255, 8'd0);
    send_sample(8'd0, 8'd0, 8'd255);
    send_sample(8'd255, 8'd255, 8'd0);
    send_sample(8'd128, 8'd128, 8'd128);
    send_sample(8'd170, 8'd85, 8'd240);
    send_sample(8'd0, 8'd255, 8'd255);
    send_sample(8'd255, 8'd0, 8'd255);
    send_sample(8'd0, 8'd0, 8'd0);

    // random part over several preset settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      load_presets(ph);
      quiet = (ph == QuietPhase);
      repeat (SamplesPerPhase) begin
        s = rand_sample();
        send_sample(s[23:16], s[15:8], s[7:0]);
      end
      quiet = 1'b0;
    end

    drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("nearest_color_classifier_core verification clean");
    end else begin
      $display("nearest_color_classifier_core verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #15_000_000;
    $display("nearest_color_classifier_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== nearest_color_classifier_core.f =====
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_if.sv
hw/rtl/ncc_cell.sv
hw/rtl/nearest_color_classifier_core.sv
bench/ncc_result_checker.sv
bench/testbench.sv
